// File: src/ddm_pkg.sv
// Shared types, constants and the sequencer microcode of the differential drive mixer.
`default_nettype none

package ddm_pkg;

  localparam int unsigned ChanW      = 11;
  localparam int unsigned DutyW      = 8;
  localparam int unsigned AccW       = 25;
  localparam int unsigned CoefW      = 26;
  localparam int unsigned ProdW      = AccW + CoefW;
  localparam int unsigned RecipShift = 32;
  localparam int unsigned BaseW      = 12;
  localparam int unsigned WheelW     = 13;
  localparam int unsigned PcW        = 5;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [DutyW-1:0]  duty_t;
  typedef logic [AccW-1:0]   acc_t;
  typedef logic [CoefW-1:0]  coef_t;
  typedef logic [ProdW-1:0]  prod_t;
  typedef logic [BaseW-1:0]  base_t;
  typedef logic [WheelW-1:0] wheel_t;
  typedef logic [PcW-1:0]    pc_t;

  // ceil(2^32 / 100): exact floor division by 100 for every accumulator value
  localparam coef_t RECIP_100       = 26'd42949673;
  localparam chan_t BRAKE_THRESHOLD = 11'd1000;
  localparam logic [7:0] TURN_SCALE_PCT = 8'd85;
  localparam logic [7:0] SPIN_RIGHT_PCT = 8'd90;
  localparam logic [7:0] SPIN_LEFT_PCT  = 8'd120;
  // duty = v * 255 / 500 = v * 51 / 100
  localparam logic [7:0] DUTY_COEF      = 8'd51;
  localparam duty_t      DUTY_MAX       = 8'd255;

  typedef enum logic [2:0] {
    CFG_FULL_SPEED    = 3'd0,
    CFG_LOW_SPEED     = 3'd1,
    CFG_TURN_FAST     = 3'd2,
    CFG_TURN_SLOW     = 3'd3,
    CFG_BALANCE_RIGHT = 3'd4,
    CFG_THROTTLE_DB   = 3'd5,
    CFG_STEER_DB      = 3'd6,
    CFG_CENTER        = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    MOTION_BRAKE    = 3'd0,
    MOTION_FORWARD  = 3'd1,
    MOTION_BACK     = 3'd2,
    MOTION_FREEZE   = 3'd3,
    MOTION_NO_FRAME = 3'd4
  } motion_t;

  typedef struct packed {
    logic  frame_valid;
    chan_t throttle_value;
    chan_t steer_value;
    chan_t brake_button;
    chan_t pivot_button;
    chan_t speed_button;
  } in_t;

  typedef struct packed {
    duty_t      right_duty;
    duty_t      left_duty;
    logic       brake_on;
    logic       reverse_right;
    logic       reverse_left;
    logic [2:0] motion;
  } out_t;

  // Multiplier request: a * b, or floor(a / 100) when div is set (b carries RECIP_100)
  typedef struct packed {
    logic  en;
    logic  div;
    acc_t  a;
    coef_t b;
  } mul_req_t;

  typedef enum logic [2:0] {
    A_ACC  = 3'd0,
    A_MAG  = 3'd1,
    A_BASE = 3'd2,
    A_RV   = 3'd3,
    A_LV   = 3'd4
  } a_sel_t;

  typedef enum logic [3:0] {
    B_SCALE  = 4'd0,
    B_TURN   = 4'd1,
    B_RECIP  = 4'd2,
    B_FAST   = 4'd3,
    B_SLOW   = 4'd4,
    B_SPIN_R = 4'd5,
    B_SPIN_L = 4'd6,
    B_BAL    = 4'd7,
    B_DUTY   = 4'd8
  } b_sel_t;

  typedef enum logic [2:0] {
    DST_NONE  = 3'd0,
    DST_BASE  = 3'd1,
    DST_OUTER = 3'd2,
    DST_INNER = 3'd3,
    DST_RDUTY = 3'd4,
    DST_LDUTY = 3'd5
  } dst_t;

  typedef struct packed {
    logic   issue;
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t   dst;
    logic   jump;
    logic   last;
  } ucode_t;

  localparam pc_t SPIN_START = 5'd0;
  localparam pc_t MOVE_START = 5'd8;
  localparam pc_t TAIL_START = 5'd14;

  function automatic ucode_t uc_op(input a_sel_t a, input b_sel_t b, input dst_t d,
                                   input logic jump, input logic last);
    ucode_t u;
    u.issue = 1'b1;
    u.a_sel = a;
    u.b_sel = b;
    u.dst   = d;
    u.jump  = jump;
    u.last  = last;
    return u;
  endfunction

  // Spin program, then move program, then one bubble and the shared duty tail
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t u;
    u = '{issue: 1'b0, a_sel: A_ACC, b_sel: B_SCALE, dst: DST_NONE, jump: 1'b0, last: 1'b1};
    unique case (pc)
      5'd0:  u = uc_op(A_MAG,  B_SCALE,  DST_NONE,  1'b0, 1'b0);
      5'd1:  u = uc_op(A_ACC,  B_TURN,   DST_NONE,  1'b0, 1'b0);
      5'd2:  u = uc_op(A_ACC,  B_RECIP,  DST_NONE,  1'b0, 1'b0);
      5'd3:  u = uc_op(A_ACC,  B_RECIP,  DST_BASE,  1'b0, 1'b0);
      5'd4:  u = uc_op(A_ACC,  B_SPIN_R, DST_NONE,  1'b0, 1'b0);
      5'd5:  u = uc_op(A_ACC,  B_RECIP,  DST_OUTER, 1'b0, 1'b0);
      5'd6:  u = uc_op(A_BASE, B_SPIN_L, DST_NONE,  1'b0, 1'b0);
      5'd7:  u = uc_op(A_ACC,  B_RECIP,  DST_INNER, 1'b1, 1'b0);
      5'd8:  u = uc_op(A_MAG,  B_SCALE,  DST_NONE,  1'b0, 1'b0);
      5'd9:  u = uc_op(A_ACC,  B_RECIP,  DST_BASE,  1'b0, 1'b0);
      5'd10: u = uc_op(A_ACC,  B_FAST,   DST_NONE,  1'b0, 1'b0);
      5'd11: u = uc_op(A_ACC,  B_RECIP,  DST_OUTER, 1'b0, 1'b0);
      5'd12: u = uc_op(A_BASE, B_SLOW,   DST_NONE,  1'b0, 1'b0);
      5'd13: u = uc_op(A_ACC,  B_RECIP,  DST_INNER, 1'b0, 1'b0);
      5'd14: u = '{issue: 1'b0, a_sel: A_ACC, b_sel: B_SCALE, dst: DST_NONE,
                   jump: 1'b0, last: 1'b0};
      5'd15: u = uc_op(A_RV,   B_BAL,    DST_NONE,  1'b0, 1'b0);
      5'd16: u = uc_op(A_ACC,  B_RECIP,  DST_NONE,  1'b0, 1'b0);
      5'd17: u = uc_op(A_ACC,  B_DUTY,   DST_NONE,  1'b0, 1'b0);
      5'd18: u = uc_op(A_ACC,  B_RECIP,  DST_RDUTY, 1'b0, 1'b0);
      5'd19: u = uc_op(A_LV,   B_DUTY,   DST_NONE,  1'b0, 1'b0);
      5'd20: u = uc_op(A_ACC,  B_RECIP,  DST_LDUTY, 1'b0, 1'b1);
      default: u = '{issue: 1'b0, a_sel: A_ACC, b_sel: B_SCALE, dst: DST_NONE,
                     jump: 1'b0, last: 1'b1};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: src/ddm_mul_unit.sv
// Shared multiplier with registered product or reciprocal divide-by-100 result.
`default_nettype none

module ddm_mul_unit (
  input  wire logic              clk,
  input  wire ddm_pkg::mul_req_t req,
  output ddm_pkg::acc_t          acc
);

  ddm_pkg::prod_t prod;

  assign prod = ddm_pkg::prod_t'(req.a) * ddm_pkg::prod_t'(req.b);

  // Keep the high part for a divide, the low part for a plain product
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.div) begin
        acc <= ddm_pkg::acc_t'(prod[ddm_pkg::ProdW-1:ddm_pkg::RecipShift]);
      end else begin
        acc <= prod[ddm_pkg::AccW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/differential_drive_mixer.sv
// Top level of the differential drive mixer: frame decode, sequencer and output beat register.
// A frame that drives the motors (move or spin) runs its microcode program, one multiplier
// pass per issuing step, then drains and loads the result beat; brake, freeze without a
// turn and no-frame beats skip the sequencer and load their result beat directly.
// in_ready is high only while idle, so a new frame waits until the last result beat is loaded.
// Reset (rst, synchronous): control and configuration registers take their defaults, low speed mode and brake on.
`default_nettype none

module differential_drive_mixer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ddm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ddm_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [10:0]   cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  // Configuration registers
  logic [6:0]     full_pct;
  logic [6:0]     low_pct;
  logic [7:0]     fast_pct;
  logic [7:0]     slow_pct;
  logic [7:0]     bal_pct;
  logic [8:0]     thr_db;
  logic [8:0]     str_db;
  ddm_pkg::chan_t center;

  // State carried from frame to frame
  logic low_speed;
  logic brake_held;
  logic right_rev;
  logic left_rev;

  // Sequencer
  state_t         state;
  ddm_pkg::pc_t   pc;
  ddm_pkg::dst_t  dst_q;
  ddm_pkg::ucode_t uc;

  // Per-frame decode, held while the sequencer runs
  ddm_pkg::motion_t motion_q;
  ddm_pkg::chan_t   dmag;
  ddm_pkg::chan_t   smag;
  logic             pivot;
  logic             back;
  logic             turn_r;
  logic             turn_l;
  logic             spin;

  // Wheel values and duties
  ddm_pkg::base_t  base;
  ddm_pkg::wheel_t outer;
  ddm_pkg::wheel_t inner;
  ddm_pkg::duty_t  rduty;
  ddm_pkg::duty_t  lduty;

  ddm_pkg::mul_req_t req;
  ddm_pkg::acc_t     acc;

  // Decode of the incoming beat
  logic           accept;
  logic           thr_above;
  logic           thr_below;
  logic           str_above;
  logic           str_below;
  ddm_pkg::chan_t dmag_w;
  ddm_pkg::chan_t smag_w;
  logic           moving;
  logic           turning;
  logic           brake;
  logic           compute;
  ddm_pkg::motion_t motion_w;

  logic            out_free;
  ddm_pkg::duty_t  acc_sat;
  ddm_pkg::wheel_t outer_e;
  ddm_pkg::wheel_t inner_e;
  ddm_pkg::wheel_t rv_w;
  ddm_pkg::wheel_t lv_w;
  logic            eff_pos;
  logic            eff_neg;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign thr_above = in_data.throttle_value > center;
  assign thr_below = in_data.throttle_value < center;
  assign str_above = in_data.steer_value > center;
  assign str_below = in_data.steer_value < center;
  assign dmag_w    = thr_above ? in_data.throttle_value - center
                               : center - in_data.throttle_value;
  assign smag_w    = str_above ? in_data.steer_value - center
                               : center - in_data.steer_value;
  assign moving    = dmag_w > ddm_pkg::chan_t'(thr_db);
  assign turning   = smag_w > ddm_pkg::chan_t'(str_db);
  assign brake     = (in_data.brake_button > ddm_pkg::BRAKE_THRESHOLD) &&
                     (in_data.brake_button != center);
  // Only forward, back and spin in place need the multiplier
  assign compute   = in_data.frame_valid && !brake && (moving || turning);

  always_comb begin
    priority if (!in_data.frame_valid) begin
      motion_w = ddm_pkg::MOTION_NO_FRAME;
    end else if (brake) begin
      motion_w = ddm_pkg::MOTION_BRAKE;
    end else if (moving) begin
      motion_w = thr_below ? ddm_pkg::MOTION_BACK : ddm_pkg::MOTION_FORWARD;
    end else begin
      motion_w = ddm_pkg::MOTION_FREEZE;
    end
  end

  // Wheel assignment: going back swaps which side is the outer wheel
  assign eff_pos = back ? turn_l : turn_r;
  assign eff_neg = back ? turn_r : turn_l;
  assign outer_e = pivot ? ddm_pkg::wheel_t'(base) : outer;
  assign inner_e = pivot ? '0 : inner;

  always_comb begin
    if (spin) begin
      rv_w = outer;
      lv_w = inner;
    end else begin
      priority if (eff_pos) begin
        rv_w = inner_e;
        lv_w = outer_e;
      end else if (eff_neg) begin
        rv_w = outer_e;
        lv_w = inner_e;
      end else begin
        rv_w = ddm_pkg::wheel_t'(base);
        lv_w = ddm_pkg::wheel_t'(base);
      end
    end
  end

  assign acc_sat = (acc > ddm_pkg::acc_t'(ddm_pkg::DUTY_MAX)) ? ddm_pkg::DUTY_MAX
                                                               : acc[ddm_pkg::DutyW-1:0];

  // Multiplier operand selection for the current microcode step
  assign uc = ddm_pkg::ucode(pc);

  always_comb begin
    req.en  = (state == ST_RUN) && uc.issue;
    req.div = (uc.b_sel == ddm_pkg::B_RECIP);
    unique case (uc.a_sel)
      ddm_pkg::A_ACC:  req.a = acc;
      ddm_pkg::A_MAG:  req.a = ddm_pkg::acc_t'(spin ? smag : dmag);
      ddm_pkg::A_BASE: req.a = ddm_pkg::acc_t'(base);
      ddm_pkg::A_RV:   req.a = ddm_pkg::acc_t'(rv_w);
      ddm_pkg::A_LV:   req.a = ddm_pkg::acc_t'(lv_w);
      default:         req.a = '0;
    endcase
    unique case (uc.b_sel)
      ddm_pkg::B_SCALE:  req.b = ddm_pkg::coef_t'(low_speed ? low_pct : full_pct);
      ddm_pkg::B_TURN:   req.b = ddm_pkg::coef_t'(ddm_pkg::TURN_SCALE_PCT);
      ddm_pkg::B_RECIP:  req.b = ddm_pkg::RECIP_100;
      ddm_pkg::B_FAST:   req.b = ddm_pkg::coef_t'(fast_pct);
      ddm_pkg::B_SLOW:   req.b = ddm_pkg::coef_t'(slow_pct);
      ddm_pkg::B_SPIN_R: req.b = ddm_pkg::coef_t'(ddm_pkg::SPIN_RIGHT_PCT);
      ddm_pkg::B_SPIN_L: req.b = ddm_pkg::coef_t'(ddm_pkg::SPIN_LEFT_PCT);
      ddm_pkg::B_BAL:    req.b = ddm_pkg::coef_t'(bal_pct);
      ddm_pkg::B_DUTY:   req.b = ddm_pkg::coef_t'(ddm_pkg::DUTY_COEF);
      default:           req.b = '0;
    endcase
  end

  ddm_mul_unit u_mul (
    .clk (clk),
    .req (req),
    .acc (acc)
  );

  // Control: configuration, carried state, sequencer and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      full_pct   <= 7'd75;
      low_pct    <= 7'd55;
      fast_pct   <= 8'd135;
      slow_pct   <= 8'd75;
      bal_pct    <= 8'd115;
      thr_db     <= 9'd25;
      str_db     <= 9'd15;
      center     <= 11'd1500;
      low_speed  <= 1'b1;
      brake_held <= 1'b1;
      right_rev  <= 1'b0;
      left_rev   <= 1'b0;
      state      <= ST_IDLE;
      pc         <= ddm_pkg::SPIN_START;
      dst_q      <= ddm_pkg::DST_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ddm_pkg::CFG_FULL_SPEED:    full_pct <= cfg_data[6:0];
          ddm_pkg::CFG_LOW_SPEED:     low_pct  <= cfg_data[6:0];
          ddm_pkg::CFG_TURN_FAST:     fast_pct <= cfg_data[7:0];
          ddm_pkg::CFG_TURN_SLOW:     slow_pct <= cfg_data[7:0];
          ddm_pkg::CFG_BALANCE_RIGHT: bal_pct  <= cfg_data[7:0];
          ddm_pkg::CFG_THROTTLE_DB:   thr_db   <= cfg_data[8:0];
          ddm_pkg::CFG_STEER_DB:      str_db   <= cfg_data[8:0];
          ddm_pkg::CFG_CENTER:        center   <= cfg_data;
          default: ;
        endcase
      end

      // Raise the output beat when a result is loaded, drop it once taken
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Route the product of the step issued now to its register next cycle
      dst_q <= ((state == ST_RUN) && uc.issue) ? uc.dst : ddm_pkg::DST_NONE;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // Update carried state now; the result reports it after this frame
            if (in_data.frame_valid) begin
              if (in_data.speed_button > center) begin
                low_speed <= 1'b1;
              end else if (in_data.speed_button < center) begin
                low_speed <= 1'b0;
              end
              if (brake) begin
                brake_held <= 1'b1;
              end else if (moving) begin
                brake_held <= 1'b0;
                right_rev  <= thr_below;
                left_rev   <= thr_below;
              end else begin
                brake_held <= 1'b0;
                if (turning) begin
                  right_rev <= str_above;
                  left_rev  <= str_below;
                end
              end
            end
            if (compute) begin
              pc    <= moving ? ddm_pkg::MOVE_START : ddm_pkg::SPIN_START;
              state <= ST_RUN;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_RUN: begin
          if (uc.last) begin
            state <= ST_DRAIN;
          end else if (uc.jump) begin
            pc <= ddm_pkg::TAIL_START;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        ST_DRAIN: begin
          // Last product lands in the left duty at this edge
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: per-frame decode, wheel values and output beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      motion_q <= motion_w;
      dmag     <= dmag_w;
      smag     <= smag_w;
      pivot    <= in_data.pivot_button < center;
      back     <= thr_below;
      turn_r   <= str_above && turning;
      turn_l   <= str_below && turning;
      spin     <= !moving;
      rduty    <= '0;
      lduty    <= '0;
    end

    // Capture the previous step's product where the microcode sent it
    unique case (dst_q)
      ddm_pkg::DST_NONE:  ;
      ddm_pkg::DST_BASE:  base  <= acc[ddm_pkg::BaseW-1:0];
      ddm_pkg::DST_OUTER: outer <= acc[ddm_pkg::WheelW-1:0];
      ddm_pkg::DST_INNER: inner <= acc[ddm_pkg::WheelW-1:0];
      ddm_pkg::DST_RDUTY: rduty <= acc_sat;
      ddm_pkg::DST_LDUTY: lduty <= acc_sat;
      default: ;
    endcase

    if ((state == ST_OUT) && out_free) begin
      out_data.right_duty    <= rduty;
      out_data.left_duty     <= lduty;
      out_data.brake_on      <= brake_held;
      out_data.reverse_right <= right_rev;
      out_data.reverse_left  <= left_rev;
      out_data.motion        <= motion_q;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the differential drive mixer: directed frames, register sweeps, random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed constants of the mixer: gains in hundredths, brake level and duty scale in raw units
  localparam int unsigned BRAKE_LEVEL = 1000;
  localparam int unsigned TURN_GAIN   = 85;
  localparam int unsigned SPIN_R_GAIN = 90;
  localparam int unsigned SPIN_L_GAIN = 120;
  localparam int unsigned DUTY_TOP    = 255;
  localparam int unsigned DUTY_SPAN   = 500;
  // Cycles with no accepted beat on any channel before the run is declared hung
  localparam int unsigned HANG_LIMIT  = 2000;

  bit            clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  ddm_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  ddm_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [10:0]   cfg_data;

  differential_drive_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the mixer registers, starting at their reset values
  bit [6:0]  pct_full    = 7'd75;
  bit [6:0]  pct_low     = 7'd55;
  bit [7:0]  pct_outer   = 8'd135;
  bit [7:0]  pct_inner   = 8'd75;
  bit [7:0]  pct_trim    = 8'd115;
  bit [8:0]  db_throttle = 9'd25;
  bit [8:0]  db_steer    = 9'd15;
  bit [10:0] center      = 11'd1500;

  // Shadow copy of the mixer state: low speed and brake held out of reset
  bit lo_mode       = 1'b1;
  bit brake_latched = 1'b1;
  bit rev_r         = 1'b0;
  bit rev_l         = 1'b0;

  ddm_pkg::out_t mix_due[$];    // predicted result beats, oldest first
  int unsigned   faults;
  bit            tx_steady;     // sender offers back to back when set
  bit            rx_steady;     // receiver never stalls when set
  int unsigned   rx_hold;       // one-shot long stall requested from the receiver
  int unsigned   quiet_cycles;

  function automatic ddm_pkg::duty_t duty_of(input int unsigned v);
    int unsigned d;
    d = v * DUTY_TOP / DUTY_SPAN;
    return (d > DUTY_TOP) ? ddm_pkg::duty_t'(DUTY_TOP) : ddm_pkg::duty_t'(d);
  endfunction

  // Predict the result of one frame and advance the shadow state
  function automatic ddm_pkg::out_t mix_frame(input ddm_pkg::in_t f);
    int unsigned      scale, vs, vt, dthr, dstr, rv, lv, outer, inner;
    int               turn, eff;
    bit               pivot, back;
    ddm_pkg::motion_t m;
    ddm_pkg::out_t    r;
    rv = 0;
    lv = 0;
    if (!f.frame_valid) begin
      // No frame: stop both motors, keep every latched state
      m = ddm_pkg::MOTION_NO_FRAME;
    end else begin
      pivot = f.pivot_button < center;
      if (f.speed_button > center) begin
        lo_mode = 1'b1;
      end else if (f.speed_button < center) begin
        lo_mode = 1'b0;
      end
      scale = lo_mode ? pct_low : pct_full;
      dthr = (f.throttle_value >= center) ? f.throttle_value - center
                                          : center - f.throttle_value;
      dstr = (f.steer_value >= center) ? f.steer_value - center : center - f.steer_value;
      vs = dthr * scale / 100;
      vt = dstr * scale * TURN_GAIN / 10000;
      turn = 0;
      if (dstr > db_steer) begin
        turn = (f.steer_value > center) ? 1 : -1;
      end
      if (f.brake_button > BRAKE_LEVEL && f.brake_button != center) begin
        m = ddm_pkg::MOTION_BRAKE;
        brake_latched = 1'b1;
      end else if (dthr > db_throttle) begin
        back = f.throttle_value < center;
        outer = pivot ? vs : vs * pct_outer / 100;
        inner = pivot ? 0 : vs * pct_inner / 100;
        eff = back ? -turn : turn;
        m = back ? ddm_pkg::MOTION_BACK : ddm_pkg::MOTION_FORWARD;
        brake_latched = 1'b0;
        rev_r = back;
        rev_l = back;
        if (eff > 0) begin
          lv = outer;
          rv = inner;
        end else if (eff < 0) begin
          lv = inner;
          rv = outer;
        end else begin
          lv = vs;
          rv = vs;
        end
      end else begin
        m = ddm_pkg::MOTION_FREEZE;
        brake_latched = 1'b0;
        if (turn != 0) begin
          rev_r = turn > 0;
          rev_l = turn < 0;
          rv = vt * SPIN_R_GAIN / 100;
          lv = vt * SPIN_L_GAIN / 100;
        end
      end
    end
    r.right_duty    = duty_of(rv * pct_trim / 100);
    r.left_duty     = duty_of(lv);
    r.brake_on      = brake_latched;
    r.reverse_right = rev_r;
    r.reverse_left  = rev_l;
    r.motion        = m;
    return r;
  endfunction

  function automatic ddm_pkg::in_t frame(input bit v, input int thr, input int str,
                                         input int a, input int b, input int c);
    ddm_pkg::in_t f;
    f.frame_valid    = v;
    f.throttle_value = ddm_pkg::chan_t'(thr);
    f.steer_value    = ddm_pkg::chan_t'(str);
    f.brake_button   = ddm_pkg::chan_t'(a);
    f.pivot_button   = ddm_pkg::chan_t'(b);
    f.speed_button   = ddm_pkg::chan_t'(c);
    return f;
  endfunction

  // Channel value at or around the center, hitting both deadband edges
  function automatic ddm_pkg::chan_t near_center(input int unsigned db);
    int v;
    int c;
    c = int'(center);
    case ($urandom_range(0, 5))
      0:       v = c;
      1:       v = c + int'(db);
      2:       v = c - int'(db);
      3:       v = c + int'(db) + 1;
      4:       v = c - int'(db) - 1;
      default: v = c + int'($urandom_range(0, 2 * db + 4)) - int'(db) - 2;
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return ddm_pkg::chan_t'(v);
  endfunction

  function automatic ddm_pkg::chan_t pick_axis(input int unsigned db);
    ddm_pkg::chan_t v;
    case ($urandom_range(0, 9))
      0:             v = '0;
      1:             v = '1;
      2, 3, 4, 5:    v = near_center(db);
      default:       v = ddm_pkg::chan_t'($urandom_range(0, 2047));
    endcase
    return v;
  endfunction

  // Mostly live frames with the brake released, so the drive paths get exercised
  function automatic ddm_pkg::in_t rand_frame();
    ddm_pkg::in_t f;
    f.frame_valid    = ($urandom_range(0, 9) != 0);
    f.throttle_value = pick_axis(db_throttle);
    f.steer_value    = pick_axis(db_steer);
    case ($urandom_range(0, 9))
      0, 1:    f.brake_button = ddm_pkg::chan_t'($urandom_range(0, 2047));
      2:       f.brake_button = center;
      3:       f.brake_button = ddm_pkg::chan_t'($urandom_range(BRAKE_LEVEL, BRAKE_LEVEL + 1));
      default: f.brake_button = ddm_pkg::chan_t'($urandom_range(0, BRAKE_LEVEL));
    endcase
    f.pivot_button = ($urandom_range(0, 3) == 0) ? near_center(0)
                                                 : ddm_pkg::chan_t'($urandom_range(0, 2047));
    f.speed_button = ($urandom_range(0, 1) == 0) ? near_center(1)
                                                 : ddm_pkg::chan_t'($urandom_range(0, 2047));
    return f;
  endfunction

  function automatic int unsigned pick_reg(input int unsigned top);
    int unsigned v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = top;
      default: v = $urandom_range(0, top);
    endcase
    return v;
  endfunction

  // Offer one frame after a random gap; predict its result on the accepting edge
  task automatic send_frame(input ddm_pkg::in_t f);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    mix_due.push_back(mix_frame(f));
  endtask

  // Drop valid and hold until every predicted beat has been taken
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mix_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input ddm_pkg::cfg_index_t idx, input int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 11'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ddm_pkg::CFG_FULL_SPEED:    pct_full    = 7'(val);
      ddm_pkg::CFG_LOW_SPEED:     pct_low     = 7'(val);
      ddm_pkg::CFG_TURN_FAST:     pct_outer   = 8'(val);
      ddm_pkg::CFG_TURN_SLOW:     pct_inner   = 8'(val);
      ddm_pkg::CFG_BALANCE_RIGHT: pct_trim    = 8'(val);
      ddm_pkg::CFG_THROTTLE_DB:   db_throttle = 9'(val);
      ddm_pkg::CFG_STEER_DB:      db_steer    = 9'(val);
      ddm_pkg::CFG_CENTER:        center      = 11'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input int unsigned full, input int unsigned low,
                           input int unsigned fast, input int unsigned slow,
                           input int unsigned bal, input int unsigned tdb,
                           input int unsigned sdb, input int unsigned ctr);
    write_reg(ddm_pkg::CFG_FULL_SPEED, full);
    write_reg(ddm_pkg::CFG_LOW_SPEED, low);
    write_reg(ddm_pkg::CFG_TURN_FAST, fast);
    write_reg(ddm_pkg::CFG_TURN_SLOW, slow);
    write_reg(ddm_pkg::CFG_BALANCE_RIGHT, bal);
    write_reg(ddm_pkg::CFG_THROTTLE_DB, tdb);
    write_reg(ddm_pkg::CFG_STEER_DB, sdb);
    write_reg(ddm_pkg::CFG_CENTER, ctr);
  endtask

  // Reset settings: one frame per mixer path, with the deadband and button edges
  task automatic test_directed_cases();
    int c;
    c = int'(center);
    // no frame, all ones elsewhere: reset brake state must show through
    send_frame(frame(0, 2047, 2047, 2047, 2047, 2047));
    send_frame(frame(1, c, c, 2047, c, c));              // brake
    send_frame(frame(1, c, c, c, c, c));                 // button A at center: no brake
    send_frame(frame(1, c + 26, c, 1000, c, c));         // A at threshold, just forward
    send_frame(frame(1, 2047, c, 1001, c, c));           // A just above threshold: brake
    send_frame(frame(1, c + 25, c + 16, 0, c, c));       // throttle on deadband: spin right
    send_frame(frame(1, c - 25, c - 16, 0, c, c));       // spin left
    send_frame(frame(1, c, c + 15, 0, c, c));            // steer on deadband: freeze still
    send_frame(frame(1, 2047, c + 16, 0, c, c - 1));     // full speed, outer wheel saturates
    send_frame(frame(1, 2047, c - 16, 0, c, c));         // speed button center holds mode
    send_frame(frame(1, 2047, 2047, 0, c - 1, c));       // pivot turn right
    send_frame(frame(1, 0, 0, 0, 0, c));                 // back, pivot, left swaps sides
    send_frame(frame(1, 0, 2047, 0, 2047, c));           // back, differential, right
    send_frame(frame(1, c - 26, c, 0, c, c));            // back, straight
    send_frame(frame(1, 0, 0, 0, c, c + 1));             // back to low speed
    send_frame(frame(0, 0, 0, 0, 0, 0));                 // no frame keeps reverse state
    send_frame(frame(1, c, 0, 0, c, 0));                 // full speed spin, far left
    send_frame(frame(1, c, 2047, 0, c, 2047));           // low speed spin, far right
    send_frame(frame(1, 0, c, 2047, c, c));              // brake keeps reverse state
    send_frame(frame(1, 0, 0, 0, 0, 0));                 // all zero frame
    send_frame(frame(1, 2047, 2047, 2047, 2047, 2047));  // all ones frame: brake
    send_frame(frame(1, c + 1, c, 0, c, c));             // freeze without turn
    wait_idle();
  endtask

  // Every register at its floor, at its ceiling, then a mixed corner
  task automatic test_register_extremes();
    write_all(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (12) send_frame(rand_frame());
    wait_idle();
    write_all(100, 100, 255, 255, 255, 500, 500, 2047);
    repeat (12) send_frame(rand_frame());
    wait_idle();
    write_all(100, 0, 255, 0, 255, 0, 500, 1024);
    repeat (12) send_frame(rand_frame());
    wait_idle();
  endtask

  // Stall the receiver for a long stretch while frames keep coming back to back
  task automatic test_output_backpressure();
    write_all(75, 55, 135, 75, 115, 25, 15, 1500);
    rx_hold   = 250;
    tx_steady = 1'b1;
    repeat (24) send_frame(rand_frame());
    tx_steady = 1'b0;
    wait_idle();
  endtask

  // Let the block drain completely between bursts
  task automatic test_sender_pause();
    repeat (10) send_frame(rand_frame());
    wait_idle();
    repeat (10) send_frame(rand_frame());
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      write_all(pick_reg(100), pick_reg(100), pick_reg(255), pick_reg(255), pick_reg(255),
                $urandom_range(0, 1) ? pick_reg(500) : $urandom_range(0, 40),
                $urandom_range(0, 1) ? pick_reg(500) : $urandom_range(0, 40),
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047)
                                            : $urandom_range(1300, 1700));
      for (int i = 0; i < 95; i++) begin
        // reshuffle idling every few dozen beats, leaving runs with no gaps at all
        if (i % 24 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 39) == 0) wait_idle();
        send_frame(rand_frame());
      end
      wait_idle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result side: draw a stall per beat, then take the beat and compare it field by field
  initial begin : result_sink
    int unsigned   stall;
    ddm_pkg::out_t got;
    ddm_pkg::out_t want;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rx_hold != 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 17);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (mix_due.size() == 0) begin
        $error("result beat arrived with no frame pending");
        faults++;
      end else begin
        want = mix_due.pop_front();
        if (got.right_duty !== want.right_duty) begin
          $error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
          faults++;
        end
        if (got.left_duty !== want.left_duty) begin
          $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
          faults++;
        end
        if (got.brake_on !== want.brake_on) begin
          $error("brake_on: expected %0d, got %0d", want.brake_on, got.brake_on);
          faults++;
        end
        if (got.reverse_right !== want.reverse_right) begin
          $error("reverse_right: expected %0d, got %0d", want.reverse_right,
                 got.reverse_right);
          faults++;
        end
        if (got.reverse_left !== want.reverse_left) begin
          $error("reverse_left: expected %0d, got %0d", want.reverse_left, got.reverse_left);
          faults++;
        end
        if (got.motion !== want.motion) begin
          $error("motion: expected %0d, got %0d", want.motion, got.motion);
          faults++;
        end
      end
      @(negedge clk);
    end
  end

  // Hang detector: count edges at which no channel moves a beat
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no beat accepted for %0d cycles", HANG_LIMIT);
    $display("FAIL differential_drive_mixer");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = ddm_pkg::CFG_FULL_SPEED;
    cfg_data  = '0;
    faults    = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    // drain, then watch a while longer for stray beats
    wait_idle();
    repeat (40) @(posedge clk);
    if (mix_due.size() != 0) begin
      $error("%0d predicted results never arrived", mix_due.size());
      faults++;
    end
    if (faults == 0) begin
      $display("PASS differential_drive_mixer");
    end else begin
      $display("FAIL differential_drive_mixer");
    end
    $finish;
  end

endmodule
